>>> hdl/hsf_pkg.sv
// Shared types, codes and helpers for the scaled HMM forward block.
// Used by hmm_scaled_forward and hsf_div; depends on nothing.
`default_nettype none
package hsf_pkg;

	typedef enum logic [1:0] {
		OP_LOAD_TRANS = 2'd0,
		OP_LOAD_EMIT  = 2'd1,
		OP_SYMBOL     = 2'd2,
		OP_FINISH     = 2'd3
	} op_t;

	localparam logic KIND_SCALE = 1'b0;
	localparam logic KIND_FINAL = 1'b1;

	localparam logic [31:0] CELL_MAX = 32'hFFFF_FFFF;

	typedef enum logic [11:0] {
		S_IDLE     = 12'b0000_0000_0001,
		S_MAC_RD   = 12'b0000_0000_0010,
		S_MAC_MUL  = 12'b0000_0000_0100,
		S_MAC_ACC  = 12'b0000_0000_1000,
		S_EMI_RD   = 12'b0000_0001_0000,
		S_EMI_MUL  = 12'b0000_0010_0000,
		S_EMI_ACC  = 12'b0000_0100_0000,
		S_SCALE    = 12'b0000_1000_0000,
		S_DIV_RD   = 12'b0001_0000_0000,
		S_DIV_INIT = 12'b0010_0000_0000,
		S_DIV_RUN  = 12'b0100_0000_0000,
		S_DONE     = 12'b1000_0000_0000
	} state_t;

	// Status of the iterative divider as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	// Saturate a wide unsigned value to one 32-bit cell.
	function automatic logic [31:0] sat_cell(input logic [63:0] v);
		sat_cell = (|v[63:32]) ? CELL_MAX : v[31:0];
	endfunction

	function automatic logic sat_flag(input logic [63:0] v);
		sat_flag = |v[63:32];
	endfunction

endpackage
`default_nettype wire

>>> hdl/hmm_scaled_forward.sv
// Scaled HMM forward recursion. A symbol request runs multiply-accumulate on the shared
// multiplier, then divides each new entry by the scaling factor on the bit-serial divider.
// A finish request runs multiply-accumulate only. One request at a time.
// Reset clears control state; the forward vector reads as its initial value through
// per-entry valid bits, the transition and emission tables are undefined until loaded.
`default_nettype none
module hmm_scaled_forward #(
	parameter int NUM_STATES    = 8,
	parameter int ALPHABET_SIZE = 4,
	parameter int FRAC_BITS     = 31
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [5:0]  from_state,
	input  wire logic [5:0]  to_state,
	input  wire logic [7:0]  symbol,
	input  wire logic [31:0] prob,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             kind,
	output logic      [31:0] value,
	output logic             error
);
	import hsf_pkg::*;

	localparam int SW    = $clog2(NUM_STATES);
	localparam int TA_W  = $clog2(NUM_STATES * NUM_STATES);
	localparam int EA_W  = $clog2(NUM_STATES * ALPHABET_SIZE);
	localparam int ACC_W = 64 - FRAC_BITS + SW;
	localparam int TOT_W = 32 + SW;
	localparam logic [31:0] ONE_VAL = 32'(64'd1 << FRAC_BITS);
	localparam logic [SW-1:0] LAST  = SW'(NUM_STATES - 1);

	state_t state_q;

	logic [31:0] t_mem [NUM_STATES*NUM_STATES];
	logic [31:0] e_mem [NUM_STATES*ALPHABET_SIZE];
	logic [31:0] fv_mem [NUM_STATES];
	logic [31:0] w_mem [NUM_STATES];
	logic [NUM_STATES-1:0] fv_valid_q;

	logic [1:0]      op_q;
	logic [7:0]      sym_q;
	logic [SW-1:0]   l_q;
	logic [SW-1:0]   k_q;
	logic [ACC_W-1:0] acc_q;
	logic [TOT_W-1:0] total_q;
	logic [31:0]     ps_q;
	logic [31:0]     scale_q;
	logic            err_q;

	logic [31:0] t_rd_q;
	logic [31:0] e_rd_q;
	logic [31:0] f_rd_q;
	logic        f_vld_q;
	logic        f_zero_idx_q;
	logic [31:0] w_rd_q;

	logic            out_valid_q;
	logic            kind_q;
	logic [31:0]     value_q;
	logic            error_q;

	logic        accept;
	logic [TA_W-1:0] t_raddr;
	logic [EA_W-1:0] e_raddr;
	logic        sym_ok;
	logic [31:0] f_val;
	logic [31:0] e_val;
	logic        mul_en;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod_q;
	logic [63:0] term;
	logic [31:0] w_new;
	logic [63:0] dividend;
	logic        q_ovf;
	logic        div_start;
	div_status_t div_st;
	logic [31:0] quot;
	logic        fv_we;
	logic [SW-1:0] fv_waddr;
	logic [31:0] fv_wdata;
	logic        out_free;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	assign t_raddr = TA_W'(k_q) * TA_W'(NUM_STATES) + TA_W'(l_q);
	assign e_raddr = EA_W'(l_q) * EA_W'(ALPHABET_SIZE) + EA_W'(sym_q);
	assign sym_ok  = 32'(sym_q) < 32'(ALPHABET_SIZE);

	// Entries never written since reset or finish hold the initial vector.
	assign f_val = f_vld_q ? f_rd_q : (f_zero_idx_q ? ONE_VAL : 32'd0);
	assign e_val = sym_ok ? e_rd_q : 32'd0;

	assign mul_en = (state_q == S_MAC_MUL) || (state_q == S_EMI_MUL);
	assign mul_a  = (state_q == S_EMI_MUL) ? ps_q : t_rd_q;
	assign mul_b  = (state_q == S_EMI_MUL) ? e_val : f_val;
	assign term   = prod_q >> FRAC_BITS;
	assign w_new  = sat_cell(term);

	assign dividend  = 64'(w_rd_q) << FRAC_BITS;
	assign q_ovf     = dividend >= {scale_q, 32'h0};
	assign div_start = (state_q == S_DIV_INIT) && (scale_q != 32'd0) && !q_ovf;

	hsf_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	hsf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (scale_q),
		.status   (div_st),
		.quot     (quot)
	);

	// Table loads and registered reads.
	always_ff @(posedge clk) begin
		if (accept && operation == OP_LOAD_TRANS &&
				32'(from_state) < 32'(NUM_STATES) && 32'(to_state) < 32'(NUM_STATES)) begin
			t_mem[TA_W'(from_state) * TA_W'(NUM_STATES) + TA_W'(to_state)] <= prob;
		end
		if (accept && operation == OP_LOAD_EMIT &&
				32'(to_state) < 32'(NUM_STATES) && 32'(symbol) < 32'(ALPHABET_SIZE)) begin
			e_mem[EA_W'(to_state) * EA_W'(ALPHABET_SIZE) + EA_W'(symbol)] <= prob;
		end
		t_rd_q <= t_mem[t_raddr];
		e_rd_q <= e_mem[e_raddr];
	end

	always_comb begin
		fv_we    = 1'b0;
		fv_waddr = l_q;
		fv_wdata = 32'd0;
		case (state_q)
			S_SCALE: begin
				fv_we    = 1'b1;
				fv_waddr = '0;
			end
			S_DIV_INIT: begin
				fv_we    = (scale_q == 32'd0) || q_ovf;
				fv_wdata = (scale_q == 32'd0) ? 32'd0 : CELL_MAX;
			end
			S_DIV_RUN: begin
				fv_we    = div_st.done;
				fv_wdata = quot;
			end
			default: begin
				fv_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (fv_we) begin
			fv_mem[fv_waddr] <= fv_wdata;
		end
		f_rd_q       <= fv_mem[k_q];
		f_zero_idx_q <= (k_q == '0);
		if (state_q == S_EMI_ACC) begin
			w_mem[l_q] <= w_new;
		end
		w_rd_q <= w_mem[l_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_valid_q <= '0;
			f_vld_q    <= 1'b0;
		end else begin
			f_vld_q <= fv_valid_q[k_q];
			if (state_q == S_DONE && out_free && op_q == OP_FINISH) begin
				fv_valid_q <= '0;
			end else if (fv_we) begin
				fv_valid_q[fv_waddr] <= 1'b1;
			end
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			op_q        <= '0;
			sym_q       <= '0;
			l_q         <= '0;
			k_q         <= '0;
			err_q       <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q  <= operation;
						sym_q <= symbol;
						err_q <= 1'b0;
						if (operation == OP_SYMBOL) begin
							l_q     <= SW'(1);
							k_q     <= '0;
							state_q <= S_MAC_RD;
						end else if (operation == OP_FINISH) begin
							l_q     <= '0;
							k_q     <= SW'(1);
							state_q <= S_MAC_RD;
						end
					end
				end
				S_MAC_RD:  state_q <= S_MAC_MUL;
				S_MAC_MUL: state_q <= S_MAC_ACC;
				S_MAC_ACC: begin
					if (k_q == LAST) begin
						state_q <= (op_q == OP_FINISH) ? S_DONE : S_EMI_RD;
					end else begin
						k_q     <= k_q + SW'(1);
						state_q <= S_MAC_RD;
					end
				end
				S_EMI_RD: begin
					err_q   <= err_q | sat_flag(64'(acc_q));
					state_q <= S_EMI_MUL;
				end
				S_EMI_MUL: state_q <= S_EMI_ACC;
				S_EMI_ACC: begin
					err_q <= err_q | sat_flag(term);
					k_q   <= '0;
					if (l_q == LAST) begin
						state_q <= S_SCALE;
					end else begin
						l_q     <= l_q + SW'(1);
						state_q <= S_MAC_RD;
					end
				end
				S_SCALE: begin
					err_q   <= err_q | sat_flag(64'(total_q)) |
						(sat_cell(64'(total_q)) == 32'd0);
					l_q     <= SW'(1);
					state_q <= S_DIV_RD;
				end
				S_DIV_RD: state_q <= S_DIV_INIT;
				S_DIV_INIT: begin
					if (div_start) begin
						state_q <= S_DIV_RUN;
					end else begin
						err_q <= err_q | (scale_q != 32'd0);
						if (l_q == LAST) begin
							state_q <= S_DONE;
						end else begin
							l_q     <= l_q + SW'(1);
							state_q <= S_DIV_RD;
						end
					end
				end
				S_DIV_RUN: begin
					if (div_st.done) begin
						if (l_q == LAST) begin
							state_q <= S_DONE;
						end else begin
							l_q     <= l_q + SW'(1);
							state_q <= S_DIV_RD;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Accumulators and result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				acc_q   <= '0;
				total_q <= '0;
			end
			S_MAC_ACC: acc_q <= acc_q + ACC_W'(term);
			S_EMI_RD:  ps_q  <= sat_cell(64'(acc_q));
			S_EMI_ACC: begin
				acc_q   <= '0;
				total_q <= total_q + TOT_W'(w_new);
			end
			S_SCALE:   scale_q <= sat_cell(64'(total_q));
			S_DONE: begin
				if (out_free) begin
					if (op_q == OP_FINISH) begin
						kind_q  <= KIND_FINAL;
						value_q <= sat_cell(64'(acc_q));
						error_q <= sat_flag(64'(acc_q));
					end else begin
						kind_q  <= KIND_SCALE;
						value_q <= scale_q;
						error_q <= err_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign value     = value_q;
	assign error     = error_q;

	a_zero_scale_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_SCALE && value == 32'd0 |-> error)
		else $error("zero scaling factor reported without error");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == S_DIV_RUN)
		else $error("divider finished outside its wait state");

	a_symbol_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (operation == OP_SYMBOL || operation == OP_FINISH) |=> state_q == S_MAC_RD)
		else $error("symbol or finish request did not start accumulation");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV_RUN && !div_st.done |-> div_st.busy)
		else $error("sequencer waits on an idle divider");
endmodule
`default_nettype wire

>>> hdl/hsf_mul.sv
// Shared 32x32 multiplier with a registered 64-bit product.
// Depends on nothing; used by the forward sequencer in the top level.
`default_nettype none
module hsf_mul (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [63:0] prod_q
);
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= 64'(a) * 64'(b);
		end
	end
endmodule
`default_nettype wire

>>> hdl/hsf_div.sv
// Restoring divider, one quotient bit per cycle, 32 quotient bits.
// Depends on hsf_pkg for the status struct.
`default_nettype none
module hsf_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [31:0] divisor,
	output hsf_pkg::div_status_t status,
	output logic      [31:0] quot
);
	import hsf_pkg::*;

	logic [31:0] rem_q;
	logic [31:0] lo_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic        fits;

	// The caller guarantees the upper half is below the divisor, so the
	// remainder always fits in 32 bits.
	assign trial = {rem_q, lo_q[31]};
	assign fits  = trial >= 33'(dvs_q);

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[63:32];
			lo_q  <= dividend[31:0];
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - 33'(dvs_q)) : trial[31:0];
			lo_q  <= {lo_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quot        = quo_q;
endmodule
`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the scaled HMM forward block (hmm_scaled_forward).
// Depends on hsf_pkg for the operation codes and on the block's RTL; needs nothing else.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hsf_pkg::*;

	localparam int NS = 8;
	localparam int NA = 4;
	localparam int FB = 31;
	localparam logic [31:0] ONE = 32'h8000_0000;

	typedef struct {
		logic        kind;
		logic [31:0] value;
		logic        error;
	} fwd_result_t;

	typedef struct {
		op_t         op;
		logic [5:0]  from_s;
		logic [5:0]  to_s;
		logic [7:0]  sym;
		logic [31:0] p;
		bit          typed;
		logic [31:0] typed_value;
		logic        typed_error;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = OP_LOAD_TRANS;
	logic [5:0]  from_state = '0;
	logic [5:0]  to_state = '0;
	logic [7:0]  symbol = '0;
	logic [31:0] prob = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic [31:0] value;
	logic        error;

	hmm_scaled_forward dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .from_state(from_state), .to_state(to_state),
		.symbol(symbol), .prob(prob),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .value(value), .error(error)
	);

	always #5 clk = ~clk;

	// Model state of the block, advanced once per accepted request.
	logic [31:0] trans_tab [NS*NS];
	logic [31:0] emit_tab [NS*NA];
	logic [31:0] alpha [NS];
	fwd_result_t pending_results [$];
	int          fail_count = 0;

	// Typed expectation for the next accepted request, if the current row carries one.
	bit          next_typed = 1'b0;
	logic [31:0] next_typed_value;
	logic        next_typed_error;

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_cycles = 0;

	function automatic logic [31:0] clamp_cell(logic [63:0] v, ref bit flag);
		if (|v[63:32]) begin
			flag = 1'b1;
			return 32'hFFFF_FFFF;
		end
		return v[31:0];
	endfunction

	function automatic logic [63:0] qmul(logic [31:0] a, logic [31:0] b);
		return (64'(a) * 64'(b)) >> FB;
	endfunction

	function automatic bit forward_step(op_t op, logic [5:0] f, logic [5:0] t,
			logic [7:0] s, logic [31:0] p, output fwd_result_t res);
		bit          sat;
		logic [63:0] acc;
		logic [63:0] total;
		logic [31:0] psum;
		logic [31:0] e;
		logic [31:0] scale;
		logic [31:0] weighted [NS];
		sat = 1'b0;
		res = '{1'b0, 32'd0, 1'b0};
		case (op)
			OP_LOAD_TRANS: begin
				if (f < NS && t < NS)
					trans_tab[f*NS + t] = p;
				return 1'b0;
			end
			OP_LOAD_EMIT: begin
				if (t < NS && s < NA)
					emit_tab[t*NA + s] = p;
				return 1'b0;
			end
			OP_SYMBOL: begin
				total = '0;
				weighted[0] = '0;
				for (int l = 1; l < NS; l++) begin
					acc = '0;
					for (int k = 0; k < NS; k++)
						acc += qmul(trans_tab[k*NS + l], alpha[k]);
					psum = clamp_cell(acc, sat);
					e = (s < NA) ? emit_tab[l*NA + s] : 32'd0;
					weighted[l] = clamp_cell(qmul(psum, e), sat);
					total += 64'(weighted[l]);
				end
				scale = clamp_cell(total, sat);
				alpha[0] = '0;
				for (int l = 1; l < NS; l++) begin
					if (scale == 0)
						alpha[l] = '0;
					else
						alpha[l] = clamp_cell((64'(weighted[l]) << FB) / 64'(scale), sat);
				end
				if (scale == 0)
					sat = 1'b1;
				res = '{KIND_SCALE, scale, sat};
				return 1'b1;
			end
			default: begin
				acc = '0;
				for (int k = 1; k < NS; k++)
					acc += qmul(trans_tab[k*NS], alpha[k]);
				res.value = clamp_cell(acc, sat);
				res.kind = KIND_FINAL;
				res.error = sat;
				foreach (alpha[i])
					alpha[i] = '0;
				alpha[0] = ONE;
				return 1'b1;
			end
		endcase
	endfunction

	// Requests are predicted when accepted; results are checked when taken.
	always @(posedge clk) begin
		fwd_result_t r;
		fwd_result_t got;
		fwd_result_t want;
		if (in_valid && in_ready) begin
			if (forward_step(op_t'(operation), from_state, to_state, symbol, prob, r)) begin
				if (next_typed) begin
					r.value = next_typed_value;
					r.error = next_typed_error;
				end
				pending_results.push_back(r);
			end
		end
		if (out_valid && out_ready) begin
			got = '{kind, value, error};
			if (pending_results.size() == 0) begin
				$error("unexpected result kind=%0d value=%h error=%0d", kind, value, error);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, got.kind);
					fail_count++;
				end
				if (got.value !== want.value) begin
					$error("value: expected %h, got %h", want.value, got.value);
					fail_count++;
				end
				if (got.error !== want.error) begin
					$error("error: expected %0d, got %0d", want.error, got.error);
					fail_count++;
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off counted here.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	task automatic send_request(op_t op, logic [5:0] f, logic [5:0] t, logic [7:0] s,
			logic [31:0] p);
		int gap;
		if ($urandom_range(99) < sender_idle_pct) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		from_state <= f;
		to_state <= t;
		symbol <= s;
		prob <= p;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_prob();
		case ($urandom_range(9))
			0: return 32'd0;
			1: return ONE;
			2: return $urandom();
			default: return $urandom_range(0, ONE);
		endcase
	endfunction

	task automatic fill_tables();
		for (int i = 0; i < NS*NS; i++)
			send_request(OP_LOAD_TRANS, 6'(i / NS), 6'(i % NS), 8'($urandom()),
				$urandom_range(0, ONE));
		for (int i = 0; i < NS*NA; i++)
			send_request(OP_LOAD_EMIT, 6'($urandom()), 6'(i / NA), 8'(i % NA),
				$urandom_range(0, ONE));
	endtask

	task automatic random_phase(int n_items);
		int  sent;
		int  run;
		op_t op;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(9))
				0: begin
					// Noise: loads with indices anywhere in the field range and any value.
					op = ($urandom_range(1)) ? OP_LOAD_TRANS : OP_LOAD_EMIT;
					send_request(op, 6'($urandom()), 6'($urandom()), 8'($urandom()),
						$urandom());
					sent++;
				end
				1, 2: begin
					op = ($urandom_range(1)) ? OP_LOAD_TRANS : OP_LOAD_EMIT;
					send_request(op, 6'($urandom_range(NS-1)), 6'($urandom_range(NS-1)),
						8'($urandom_range(NA-1)), rand_prob());
					sent++;
				end
				default: begin
					run = $urandom_range(1, 6);
					for (int i = 0; i < run; i++) begin
						send_request(OP_SYMBOL, 6'($urandom()), 6'($urandom()),
							($urandom_range(19) == 0) ? 8'($urandom()) :
								8'($urandom_range(NA-1)),
							$urandom());
						sent++;
					end
					if ($urandom_range(4) != 0) begin
						send_request(OP_FINISH, 6'($urandom()), 6'($urandom()),
							8'($urandom()), $urandom());
						sent++;
					end
				end
			endcase
		end
	endtask

	stim_row_t directed_rows [] = '{
		// Fresh vector: only the begin state is live, so nothing reaches the end state.
		'{OP_FINISH,     6'd0,  6'd0,  8'd0,   32'd0,         1'b1, 32'd0, 1'b0},
		'{OP_SYMBOL,     6'd0,  6'd0,  8'd0,   32'd0,         1'b0, 32'd0, 1'b0},
		'{OP_SYMBOL,     6'd63, 6'd63, 8'd3,   32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0},
		'{OP_SYMBOL,     6'd0,  6'd0,  8'd1,   32'd0,         1'b0, 32'd0, 1'b0},
		'{OP_FINISH,     6'd0,  6'd0,  8'd0,   32'd0,         1'b0, 32'd0, 1'b0},
		// Symbol beyond the alphabet reads zero emissions: zero factor, error.
		'{OP_SYMBOL,     6'd0,  6'd0,  8'd4,   32'd0,         1'b1, 32'd0, 1'b1},
		'{OP_SYMBOL,     6'd0,  6'd0,  8'd255, 32'd0,         1'b1, 32'd0, 1'b1},
		// The vector is all zero now, so the end probability is zero without error.
		'{OP_FINISH,     6'd0,  6'd0,  8'd0,   32'd0,         1'b1, 32'd0, 1'b0},
		'{OP_LOAD_TRANS, 6'd8,  6'd0,  8'd0,   32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0},
		'{OP_LOAD_TRANS, 6'd0,  6'd63, 8'd0,   32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0},
		'{OP_LOAD_EMIT,  6'd0,  6'd1,  8'd4,   32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0},
		'{OP_LOAD_EMIT,  6'd0,  6'd63, 8'd0,   32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0},
		'{OP_LOAD_TRANS, 6'd0,  6'd1,  8'd0,   32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0},
		'{OP_LOAD_EMIT,  6'd0,  6'd1,  8'd2,   32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0},
		'{OP_LOAD_TRANS, 6'd7,  6'd0,  8'd0,   32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0},
		'{OP_SYMBOL,     6'd0,  6'd0,  8'd2,   32'd0,         1'b0, 32'd0, 1'b0},
		'{OP_SYMBOL,     6'd0,  6'd0,  8'd2,   32'd0,         1'b0, 32'd0, 1'b0},
		'{OP_FINISH,     6'd0,  6'd0,  8'd0,   32'd0,         1'b0, 32'd0, 1'b0},
		'{OP_LOAD_TRANS, 6'd0,  6'd1,  8'd0,   ONE,           1'b0, 32'd0, 1'b0},
		'{OP_LOAD_EMIT,  6'd0,  6'd1,  8'd2,   32'd0,         1'b0, 32'd0, 1'b0},
		'{OP_LOAD_TRANS, 6'd7,  6'd0,  8'd0,   32'd0,         1'b0, 32'd0, 1'b0},
		'{OP_SYMBOL,     6'd0,  6'd0,  8'd2,   32'd0,         1'b0, 32'd0, 1'b0},
		'{OP_FINISH,     6'd0,  6'd0,  8'd0,   32'd0,         1'b0, 32'd0, 1'b0}
	};

	initial begin
		foreach (alpha[i])
			alpha[i] = '0;
		alpha[0] = ONE;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		fill_tables();
		foreach (directed_rows[i]) begin
			// Updated after the checker has seen the previous acceptance edge.
			next_typed <= directed_rows[i].typed;
			next_typed_value <= directed_rows[i].typed_value;
			next_typed_error <= directed_rows[i].typed_error;
			send_request(directed_rows[i].op, directed_rows[i].from_s, directed_rows[i].to_s,
				directed_rows[i].sym, directed_rows[i].p);
		end
		next_typed <= 1'b0;
		drain_results();

		// Long receiver hold-off while requests keep coming, so the input stalls.
		hold_cycles = 1500;
		random_phase(20);

		sender_idle_pct = 0;   receiver_stall_pct = 0;  random_phase(270);
		sender_idle_pct = 67;  receiver_stall_pct = 0;  random_phase(270);
		drain_results();
		sender_idle_pct = 0;   receiver_stall_pct = 67; random_phase(270);
		sender_idle_pct = 36;  receiver_stall_pct = 36; random_phase(270);

		drain_results();
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
